// ----- design/jts_pkg.sv -----
// ----------------------------------------------------------------------------
// jts_pkg
// Shared types and constants for the joint trajectory segmenter.
// ----------------------------------------------------------------------------
package jts_pkg;

    localparam int MAX_POINTS = 64;
    localparam int FULL_TURN  = 36000;
    localparam int MIN_SPEED  = 100;
    localparam int MS_SCALE   = 1000;
    localparam int PCT_SCALE  = 100;

    localparam int ANG_W   = 17;
    localparam int SPD_W   = 20;
    localparam int CNT_W   = 8;
    localparam int TIME_W  = 32;
    localparam int SERVO_W = 8;
    localparam int PROG_W  = 7;
    localparam int WIDE_W  = 21;
    localparam int TGT_W   = 19;
    localparam int DELTA_W = 17;
    localparam int QUO_W   = 27;
    localparam int REM_W   = 32;
    localparam int DIV_STEPS = QUO_W;
    localparam int STEP_W  = 5;
    localparam int IN_W    = 96;
    localparam int OUT_W   = 128;

    localparam logic [SPD_W-1:0] MAX_SPEED_RESET = SPD_W'(18000);

    typedef enum logic [0:0] {
        REG_POINT_COUNT = 1'b0,
        REG_MAX_SPEED   = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UNWRAP,
        S_LOAD,
        S_DIV,
        S_SPD,
        S_PLOAD,
        S_PDIV,
        S_PSTORE,
        S_EMIT,
        S_REJECT
    } state_t;

    typedef struct packed {
        logic       accept;
        logic [1:0] sel;
        logic       unwrap;
        logic       div_load_spd;
        logic       div_load_prog;
        logic       div_step;
        logic       spd_store;
        logic       prog_store;
        logic       emit;
        logic       emit_reject;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic first;
        logic out_busy;
    } sts_t;

endpackage

// ----- design/jts_ctrl.sv -----
// ----------------------------------------------------------------------------
// jts_ctrl
// Sequencer that steps the datapath through unwrap, speed and progress work.
// ----------------------------------------------------------------------------
module jts_ctrl
    import jts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t              state_reg, state_next;
    logic [1:0]          sel_reg, sel_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 2'd0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    sel_next = 2'd0;
                    if (sts.bad)
                        state_next = S_REJECT;
                    else if (!sts.first)
                        state_next = S_UNWRAP;
                end
            end
            S_UNWRAP: state_next = S_LOAD;
            S_LOAD:
            begin
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = S_SPD;
            end
            S_SPD:
            begin
                if (sel_reg == 2'd2)
                    state_next = S_PLOAD;
                else
                begin
                    sel_next   = sel_reg + 2'd1;
                    state_next = S_UNWRAP;
                end
            end
            S_PLOAD:
            begin
                step_next  = '0;
                state_next = S_PDIV;
            end
            S_PDIV:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    state_next = S_PSTORE;
            end
            S_PSTORE: state_next = S_EMIT;
            S_EMIT:
            begin
                if (!sts.out_busy)
                    state_next = S_IDLE;
            end
            S_REJECT:
            begin
                if (!sts.out_busy)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.sel      = sel_reg;
        s_tready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            S_UNWRAP: cmd.unwrap        = 1'b1;
            S_LOAD:   cmd.div_load_spd  = 1'b1;
            S_DIV:    cmd.div_step      = 1'b1;
            S_SPD:    cmd.spd_store     = 1'b1;
            S_PLOAD:  cmd.div_load_prog = 1'b1;
            S_PDIV:   cmd.div_step      = 1'b1;
            S_PSTORE: cmd.prog_store    = 1'b1;
            S_EMIT:   cmd.emit          = !sts.out_busy;
            S_REJECT: cmd.emit_reject   = !sts.out_busy;
            default:  cmd = '0;
        endcase
    end

endmodule

// ----- design/jts_dpath.sv -----
// ----------------------------------------------------------------------------
// jts_dpath
// Point state, unwrap unit, shared serial divider and output register.
// ----------------------------------------------------------------------------
module jts_dpath
    import jts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [IN_W-1:0]    s_tdata,
    input  logic               s_tuser,
    input  logic               cfg_valid,
    input  logic [0:0]         cfg_index,
    input  logic [SPD_W-1:0]   cfg_data,
    input  cmd_t               cmd,
    output sts_t               sts,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata,
    output logic               m_tuser,
    output logic               m_tlast
);

    logic [CNT_W-1:0]   pc_reg;
    logic [SPD_W-1:0]   max_reg;
    logic               have_prev_reg;
    logic [TIME_W-1:0]  prev_time_reg;
    logic [ANG_W-1:0]   prev_ang_reg [3];
    logic [CNT_W-1:0]   seg_reg;
    logic [ANG_W-1:0]   in_ang_reg [3];
    logic               vac_reg;
    logic [SERVO_W-1:0] servo_reg;
    logic [TIME_W-2:0]  dur_reg;
    logic [TIME_W-1:0]  diff_hold;
    logic [TGT_W-1:0]   tgt_reg [3];
    logic [DELTA_W-1:0] delta_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [REM_W-1:0]   dvsr_reg;
    logic [SPD_W-1:0]   spd_reg [3];
    logic [PROG_W-1:0]  prog_reg;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic               out_user_reg;
    logic               out_last_reg;

    logic [TIME_W-1:0]  in_time;
    logic [ANG_W-1:0]   in_ang [3];
    logic [TIME_W-1:0]  diff;
    logic signed [WIDE_W-1:0] ua, up, best, best_err, cand, err;
    logic [REM_W-1:0]   rem_shift;
    logic               qbit;
    logic [SPD_W-1:0]   spd_clamped;
    logic [TGT_W-1:0]   sat [3];
    logic               done;
    logic [CNT_W:0]     seg_inc;

    assign in_time   = s_tdata[31:0];
    assign in_ang[0] = s_tdata[48:32];
    assign in_ang[1] = s_tdata[65:49];
    assign in_ang[2] = s_tdata[82:66];

    assign sts.bad      = (pc_reg < CNT_W'(2)) || (pc_reg > CNT_W'(MAX_POINTS));
    assign sts.first    = s_tuser || !have_prev_reg;
    assign sts.out_busy = out_valid_reg;

    assign diff = in_time - prev_time_reg;

    always_comb
    begin
        ua       = WIDE_W'(signed'(in_ang_reg[cmd.sel]));
        up       = WIDE_W'(signed'(prev_ang_reg[cmd.sel]));
        best     = ua;
        best_err = (ua - up < 0) ? up - ua : ua - up;
        cand     = '0;
        err      = '0;
        for (int k = -3; k <= 3; k++)
        begin
            cand = ua + WIDE_W'(FULL_TURN * k);
            err  = (cand - up < 0) ? up - cand : cand - up;
            if (err < best_err)
            begin
                best     = cand;
                best_err = err;
            end
        end
    end

    assign rem_shift = {rem_reg[REM_W-2:0], quo_reg[QUO_W-1]};
    assign qbit      = (rem_shift >= dvsr_reg);

    always_comb
    begin
        if (quo_reg < QUO_W'(MIN_SPEED))
            spd_clamped = SPD_W'(MIN_SPEED);
        else if (quo_reg > QUO_W'(max_reg))
            spd_clamped = max_reg;
        else
            spd_clamped = quo_reg[SPD_W-1:0];
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (signed'(tgt_reg[j]) > signed'(TGT_W'(65535)))
                sat[j] = TGT_W'(65535);
            else if (signed'(tgt_reg[j]) < signed'(-TGT_W'(65536)))
                sat[j] = -TGT_W'(65536);
            else
                sat[j] = tgt_reg[j];
        end
    end

    assign seg_inc = {1'b0, seg_reg} + (CNT_W+1)'(1);
    assign done    = seg_inc >= ({1'b0, pc_reg} - (CNT_W+1)'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            max_reg       <= MAX_SPEED_RESET;
            have_prev_reg <= 1'b0;
            prev_time_reg <= '0;
            prev_ang_reg  <= '{default: '0};
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_POINT_COUNT: pc_reg  <= cfg_data[CNT_W-1:0];
                    REG_MAX_SPEED:   max_reg <= cfg_data;
                    default:         pc_reg  <= pc_reg;
                endcase
            end
            if (cmd.accept && !sts.bad && sts.first)
            begin
                have_prev_reg <= 1'b1;
                seg_reg       <= '0;
                prev_time_reg <= in_time;
                prev_ang_reg  <= in_ang;
            end
            if (cmd.emit)
            begin
                prev_time_reg <= prev_time_reg + TIME_W'(diff_hold);
                prev_ang_reg  <= in_ang_reg;
                if (done)
                begin
                    have_prev_reg <= 1'b0;
                    seg_reg       <= '0;
                end
                else
                    seg_reg <= seg_inc[CNT_W-1:0];
            end
            if (cmd.emit || cmd.emit_reject)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_ang_reg <= in_ang;
            vac_reg    <= s_tdata[83];
            servo_reg  <= s_tdata[91:84];
            diff_hold  <= diff;
            if (diff == '0 || diff[TIME_W-1])
                dur_reg <= (TIME_W-1)'(1);
            else
                dur_reg <= diff[TIME_W-2:0];
        end
        if (cmd.unwrap)
        begin
            tgt_reg[cmd.sel] <= best[TGT_W-1:0];
            delta_reg        <= best_err[DELTA_W-1:0];
        end
        if (cmd.div_load_spd)
        begin
            rem_reg  <= '0;
            quo_reg  <= QUO_W'(delta_reg) * QUO_W'(MS_SCALE);
            dvsr_reg <= REM_W'(dur_reg);
        end
        if (cmd.div_load_prog)
        begin
            rem_reg  <= '0;
            quo_reg  <= QUO_W'(seg_inc) * QUO_W'(PCT_SCALE);
            dvsr_reg <= REM_W'(pc_reg) - REM_W'(1);
        end
        if (cmd.div_step)
        begin
            rem_reg <= qbit ? rem_shift - dvsr_reg : rem_shift;
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
        end
        if (cmd.spd_store)
            spd_reg[cmd.sel] <= spd_clamped;
        if (cmd.prog_store)
            prog_reg <= (quo_reg > QUO_W'(PCT_SCALE)) ? PROG_W'(PCT_SCALE)
                                                      : quo_reg[PROG_W-1:0];
        if (cmd.emit)
        begin
            out_data_reg <= {1'b0, prog_reg, servo_reg, vac_reg,
                             spd_reg[2], spd_reg[1], spd_reg[0],
                             sat[2][ANG_W-1:0], sat[1][ANG_W-1:0], sat[0][ANG_W-1:0]};
            out_user_reg <= 1'b0;
            out_last_reg <= done;
        end
        if (cmd.emit_reject)
        begin
            out_data_reg <= '0;
            out_user_reg <= 1'b1;
            out_last_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- design/joint_trajectory_segmenter.sv -----
// ----------------------------------------------------------------------------
// joint_trajectory_segmenter
// Turns a stream of trajectory points into per-segment joint commands.
// ----------------------------------------------------------------------------
// The slave channel takes one trajectory point per item; s_tuser flags a
// restart. The master channel gives one command per point after the first
// of a trajectory, or one reject item (m_tuser high) per point while the
// point count is out of range. m_tlast marks the final segment.
// The configuration channel writes the point count and the speed clamp; it
// is always ready and should be used only while the block is idle.
// For a segment point, three speed divisions and one progress division each
// run 27 steps on one shared restoring divider, between unwrap, load, store
// and emit states. A first point is only stored and yields no command, and a
// rejected point goes straight from idle to a reject state that emits it.
// One item is processed at a time, from its acceptance until its emit.
// The finished command sits in an output register; the block accepts the
// next point while it waits, and stalls before its own result only if that
// register is still full. Reset clears the stored point, the segment count
// and the configuration to their defaults.
// ----------------------------------------------------------------------------
module joint_trajectory_segmenter
    import jts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // point_time_ms, joint0_angle, joint1_angle, joint2_angle,
    // vacuum_request, servo_request, zero fill.
    input  logic [IN_W-1:0]    s_tdata,
    // restart.
    input  logic               s_tuser,
    input  logic               s_tvalid,
    output logic               s_tready,
    // joint0..2_target, joint0..2_speed, vacuum_on, servo position,
    // progress_pct, zero fill.
    output logic [OUT_W-1:0]   m_tdata,
    // status.
    output logic               m_tuser,
    // trajectory_done.
    output logic               m_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [SPD_W-1:0]   cfg_data
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    jts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    jts_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
